[design/utf8_pkg.sv]
// Package for the UTF-8 to UCS-2 decoder: result type, constants and lead-byte decode.
`timescale 1ns / 1ps

package utf8_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        string_end;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        has_res;
        res_t        res;
        logic [1:0]  pending;
        logic [20:0] partial;
    } lead_t;

    // Decode a byte seen where a lead byte is expected.
    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t l;
        l = '0;
        l.res.last = 1'b1;
        if (b == 8'h00) begin
            l.has_res = 1'b1;
            l.res.string_end = 1'b1;
        end else if (b <= 8'h7F) begin
            l.has_res = 1'b1;
            l.res.code_unit = {8'h00, b};
        end else if (b < 8'hC2) begin
            l.has_res = 1'b1;
        end else if (b < 8'hE0) begin
            l.pending = 2'd1;
            l.partial = {16'h0000, b[4:0]};
        end else if (b < 8'hF0) begin
            l.pending = 2'd2;
            l.partial = {17'h00000, b[3:0]};
        end else if (b < 8'hF5) begin
            l.pending = 2'd3;
            l.partial = {18'h00000, b[2:0]};
        end else begin
            l.has_res = 1'b1;
        end
        return l;
    endfunction

    // Values outside the basic plane map to zero.
    function automatic logic [15:0] to_ucs2(input logic [20:0] code);
        return (code[20:16] == 5'd0) ? code[15:0] : 16'h0000;
    endfunction

endpackage

[design/utf8_to_ucs2_decoder_unit.sv]
// UTF-8 to UCS-2 decoder top level: byte decode and a two-entry result queue.
//
// Input channel s_valid / s_ready / s_in_byte carries one UTF-8 byte per item;
// a zero byte ends the string. Output channel m_valid / m_ready carries one
// UCS-2 code unit per item with m_string_end on the terminator and m_last on
// the final result caused by an input byte.
// Each input byte is decoded in the cycle it is accepted and its results
// (zero, one or two) are written to a two-entry result queue; the first
// result is visible on the next cycle.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver keeps m_ready high. A byte that gives two results (broken
// sequence or zero inside a sequence) fills both queue entries, so the next
// byte waits until the first of them is taken. A byte is taken only when the
// queue will be empty after this cycle's output transfer.
// Reset (aresetn low, synchronous) empties the queue and returns the decoder
// to expecting a lead byte. When the receiver stalls with a result queued,
// s_ready drops; held results stay stable until taken.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_string_end,
    output logic        m_last
);

    logic [1:0]          pending_reg, pending_next;
    logic [20:0]         partial_reg, partial_next;
    logic [1:0]          count_reg, count_next;
    utf8_pkg::res_t      q0_reg, q0_next, q1_reg, q1_next;

    utf8_pkg::lead_t     lead;
    utf8_pkg::res_t      r0, r1;
    logic [1:0]          n_res;
    logic [20:0]         shifted;
    logic [1:0]          pending_dec;
    logic                accept, pop;

    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign accept  = s_valid && s_ready;

    assign lead        = utf8_pkg::lead_decode(s_in_byte);
    assign shifted     = {partial_reg[14:0], s_in_byte[5:0]};
    assign pending_dec = pending_reg - 2'd1;

    always_comb begin
        n_res        = 2'd0;
        r0           = '0;
        r1           = '0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (pending_reg == 2'd0) begin
            pending_next = lead.pending;
            partial_next = lead.partial;
            if (lead.has_res) begin
                n_res = 2'd1;
                r0    = lead.res;
            end
        end else if (s_in_byte == 8'h00) begin
            n_res         = 2'd2;
            r0.code_unit  = utf8_pkg::to_ucs2(partial_reg);
            r1.string_end = 1'b1;
            r1.last       = 1'b1;
            pending_next  = 2'd0;
            partial_next  = '0;
        end else if (s_in_byte[7:6] == 2'b10) begin
            pending_next = pending_dec;
            if (pending_dec == 2'd0) begin
                n_res        = 2'd1;
                r0.code_unit = utf8_pkg::to_ucs2(shifted);
                r0.last      = 1'b1;
                partial_next = '0;
            end else begin
                partial_next = shifted;
            end
        end else begin
            // broken sequence: replacement, then the byte again as a lead
            r0.code_unit = utf8_pkg::REPLACEMENT;
            r0.last      = !lead.has_res;
            pending_next = lead.pending;
            partial_next = lead.partial;
            if (lead.has_res) begin
                n_res = 2'd2;
                r1    = lead.res;
            end else begin
                n_res = 2'd1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (accept) begin
            count_next = n_res;
            q0_next    = r0;
            q1_next    = r1;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            q0_next    = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            count_reg   <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_valid      = (count_reg != 2'd0);
    assign m_code_unit  = q0_reg.code_unit;
    assign m_string_end = q0_reg.string_end;
    assign m_last       = q0_reg.last;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_code_unit == 16'h0000 && m_last)
        else $error("terminator result malformed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_in_byte == 8'h00 |=> pending_reg == 2'd0)
        else $error("decoder not back at lead state after terminator");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> count_reg == 2'd2)
        else $error("first of two results queued without its partner");

endmodule
